// File: hw/rtl/dead_column_pixel_classifier_core_assert.svh
// Assertion macros used by the dead column pixel classifier job queue.
`ifndef DEAD_COLUMN_PIXEL_CLASSIFIER_CORE_ASSERT_SVH
`define DEAD_COLUMN_PIXEL_CLASSIFIER_CORE_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define DCPC_ASSERT_SAME(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error(msg);

// Checks that a condition implies another in the next cycle.
`define DCPC_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: hw/rtl/dcpc_pkg.sv
// Package with types and constants of the dead column pixel classifier.
`default_nettype none
package dcpc_pkg;
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_HEIGHT      = 4096;
    localparam int MIN_DIM         = 5;
    localparam int QUEUE_DEPTH     = 4;
    localparam int POS_W           = 12;
    localparam int TALLY_W         = 25;
    localparam int DIM_W           = 16;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 25'h1000000;

    localparam int FLAG_LOW   = 0;
    localparam int FLAG_OVER3 = 1;
    localparam int FLAG_OVER4 = 2;

    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_MEAN_LEVEL    = 3'd2;
    localparam logic [2:0] REG_NOISE_SIGMA   = 3'd3;
    localparam logic [2:0] REG_REF_THRESHOLD = 3'd4;

    typedef enum logic [1:0] {
        CLASS_CLEAN   = 2'd0,
        CLASS_BOTH    = 2'd1,
        CLASS_ADDED   = 2'd2,
        CLASS_MISSING = 2'd3
    } class_t;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] mean_level;
        logic [13:0] noise_sigma;
        logic [15:0] ref_threshold;
    } cfg_t;

    typedef struct packed {
        logic             dead;
        logic             ref_old;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
        logic             clear;
    } job_t;
endpackage
`default_nettype wire

// File: hw/rtl/dcpc_ram.sv
// Generic simple dual-port RAM with registered read-first output.
`default_nettype none
module dcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/dcpc_queue.sv
// Short job queue between the front and back parts.
`default_nettype none
`include "dead_column_pixel_classifier_core_assert.svh"
module dcpc_queue #(
    parameter int DEPTH = dcpc_pkg::QUEUE_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire dcpc_pkg::job_t             push_job,
    input  wire logic                       pop,
    output logic                            q_valid,
    output dcpc_pkg::job_t                  q_job,
    output logic [$clog2(DEPTH+1)-1:0]      q_level
);
    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    dcpc_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + LW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_job   = mem_reg[rd_ptr_reg];
    assign q_level = count_reg;

    `DCPC_ASSERT_SAME(a_no_overflow, count_reg == LW'(DEPTH), !push || pop, "queue overflow")
    `DCPC_ASSERT_SAME(a_no_underflow, pop, count_reg != '0, "queue underflow")
    `DCPC_ASSERT_NEXT(a_level_hold, push && pop, $stable(count_reg), "queue level moved")
endmodule
`default_nettype wire

// File: hw/rtl/dcpc_front.sv
// Front part: position tracking, flag line memories and dead pixel decision.
`default_nettype none
module dcpc_front #(
    parameter int MAX_WIDTH   = dcpc_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = dcpc_pkg::SAMPLE_BITS_DEF,
    parameter int QDEPTH      = dcpc_pkg::QUEUE_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dcpc_pkg::cfg_t              cfg,
    input  wire logic                        pix_valid,
    output logic                             pix_ready,
    input  wire logic [15:0]                 pixel_value,
    input  wire logic [15:0]                 ref_value,
    input  wire logic                        start_of_frame,
    input  wire logic [$clog2(QDEPTH+1)-1:0] q_level,
    output logic                             push,
    output dcpc_pkg::job_t                   push_job
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = CW - 1;
    localparam int DW = dcpc_pkg::DIM_W;
    localparam int LW = $clog2(QDEPTH+1);
    localparam int PW = dcpc_pkg::POS_W;
    localparam logic [15:0] SMASK = 16'((33'd1 << SAMPLE_BITS) - 33'd1);

    logic [CW-1:0] col_reg;
    logic [PW-1:0] row_reg;
    logic [1:0]    slot_reg;
    logic          pend_clear_reg;

    logic          f1_valid_reg;
    logic [PW-1:0] f1_col_reg, f1_row_reg;
    logic          f1_last_reg, f1_clear_reg, f1_byp_reg;
    logic [2:0]    f1_byp_flags_reg;
    logic [1:0]    f1_top_reg, f1_mid_reg, f1_cur_reg;

    logic [DW-1:0] w_eff, h_eff, c16, r16;
    logic [CW-1:0] c_cur;
    logic [PW-1:0] r_cur;
    logic [1:0]    slot_cur, slot_top, slot_mid;
    logic          accept, emit, anchor_wr, ref_now, at_origin;
    logic [15:0]   pv, rv, dev, t3, t4;
    logic [2:0]    flags;
    logic [AW-1:0] k;

    logic [2:0] rd [3][3];
    logic       ref_old;

    always_comb begin
        w_eff = DW'(cfg.frame_width);
        if (cfg.frame_width < 13'(dcpc_pkg::MIN_DIM)) begin
            w_eff = DW'(dcpc_pkg::MIN_DIM);
        end else if (DW'(cfg.frame_width) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end
        h_eff = DW'(cfg.frame_height);
        if (cfg.frame_height < 13'(dcpc_pkg::MIN_DIM)) begin
            h_eff = DW'(dcpc_pkg::MIN_DIM);
        end else if (DW'(cfg.frame_height) > DW'(dcpc_pkg::MAX_HEIGHT)) begin
            h_eff = DW'(dcpc_pkg::MAX_HEIGHT);
        end
    end

    assign pix_ready = (LW'(32'(q_level) + 32'(f1_valid_reg)) < LW'(QDEPTH));
    assign accept    = pix_valid && pix_ready;

    assign c_cur    = start_of_frame ? '0 : col_reg;
    assign r_cur    = start_of_frame ? '0 : row_reg;
    assign slot_cur = start_of_frame ? 2'd0 : slot_reg;
    assign slot_top = (slot_cur == 2'd2) ? 2'd0 : slot_cur + 2'd1;
    assign slot_mid = (slot_cur == 2'd0) ? 2'd2 : slot_cur - 2'd1;
    assign c16      = DW'(c_cur);
    assign r16      = DW'(r_cur);
    assign k        = c_cur[CW-1:1];

    assign at_origin = (c_cur == '0) && (r_cur == '0);
    assign emit = (r16 >= DW'(4)) && (r16 < h_eff) && (c16 >= DW'(2))
                  && (c16 + DW'(3) <= w_eff);
    assign anchor_wr = !c_cur[0] && !r_cur[0];

    assign pv  = pixel_value & SMASK;
    assign rv  = ref_value & SMASK;
    assign dev = (pv > cfg.mean_level) ? pv - cfg.mean_level : cfg.mean_level - pv;
    assign t3  = 16'({2'b00, cfg.noise_sigma}) + {1'b0, cfg.noise_sigma, 1'b0};
    assign t4  = {cfg.noise_sigma, 2'b00};
    assign ref_now = rv > cfg.ref_threshold;

    always_comb begin
        flags = '0;
        flags[dcpc_pkg::FLAG_LOW]   = dev < t3;
        flags[dcpc_pkg::FLAG_OVER3] = dev > t3;
        flags[dcpc_pkg::FLAG_OVER4] = dev > t4;
    end

    for (genvar s = 0; s < 3; s++) begin : g_slot
        for (genvar j = 0; j < 3; j++) begin : g_copy
            logic [AW-1:0] raddr;
            assign raddr = (slot_mid == 2'(s)) ? k + AW'(j) - AW'(1) : k;
            dcpc_ram #(
                .WIDTH(3),
                .DEPTH(MAX_WIDTH / 2)
            ) u_anchor_ram (
                .aclk (aclk),
                .we   (accept && anchor_wr && (slot_cur == 2'(s))),
                .waddr(k),
                .wdata(flags),
                .raddr(raddr),
                .rdata(rd[s][j])
            );
        end
    end

    dcpc_ram #(
        .WIDTH(1),
        .DEPTH(2 * MAX_WIDTH)
    ) u_ref_ram (
        .aclk (aclk),
        .we   (accept),
        .waddr({r_cur[0], c_cur}),
        .wdata(ref_now),
        .raddr({r_cur[0], c_cur}),
        .rdata(ref_old)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            slot_reg       <= '0;
            pend_clear_reg <= 1'b0;
            f1_valid_reg   <= 1'b0;
        end else begin
            f1_valid_reg <= accept && emit;
            if (accept) begin
                if (at_origin) begin
                    pend_clear_reg <= 1'b1;
                end else if (emit) begin
                    pend_clear_reg <= 1'b0;
                end
                if (c16 + DW'(1) >= w_eff) begin
                    col_reg <= '0;
                    if (r16 + DW'(1) >= h_eff) begin
                        row_reg  <= '0;
                        slot_reg <= 2'd0;
                    end else begin
                        row_reg  <= r_cur + PW'(1);
                        slot_reg <= r_cur[0] ? slot_top : slot_cur;
                    end
                end else begin
                    col_reg  <= c_cur + CW'(1);
                    row_reg  <= r_cur;
                    slot_reg <= slot_cur;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_col_reg       <= PW'(c_cur);
            f1_row_reg       <= r_cur - PW'(2);
            f1_last_reg      <= (c16 + DW'(3) == w_eff) && (r16 + DW'(1) == h_eff);
            f1_clear_reg     <= pend_clear_reg;
            f1_byp_reg       <= anchor_wr;
            f1_byp_flags_reg <= flags;
            f1_top_reg       <= slot_top;
            f1_mid_reg       <= slot_mid;
            f1_cur_reg       <= slot_cur;
        end
    end

    logic [2:0] ctr, nb_up, nb_dn, nb_lf, nb_rt;
    logic [2:0] n3, n4;
    logic       dead;

    always_comb begin
        ctr   = rd[f1_mid_reg][1];
        nb_lf = rd[f1_mid_reg][0];
        nb_rt = rd[f1_mid_reg][2];
        nb_up = rd[f1_top_reg][0];
        nb_dn = f1_byp_reg ? f1_byp_flags_reg : rd[f1_cur_reg][0];
        n3 = 3'(nb_up[dcpc_pkg::FLAG_OVER3]) + 3'(nb_dn[dcpc_pkg::FLAG_OVER3])
           + 3'(nb_lf[dcpc_pkg::FLAG_OVER3]) + 3'(nb_rt[dcpc_pkg::FLAG_OVER3]);
        n4 = 3'(nb_up[dcpc_pkg::FLAG_OVER4]) + 3'(nb_dn[dcpc_pkg::FLAG_OVER4])
           + 3'(nb_lf[dcpc_pkg::FLAG_OVER4]) + 3'(nb_rt[dcpc_pkg::FLAG_OVER4]);
        dead = !ctr[dcpc_pkg::FLAG_LOW]
               && ((n4 >= 3'd2) || (ctr[dcpc_pkg::FLAG_OVER4] && (n3 >= 3'd2)));
    end

    assign push           = f1_valid_reg;
    assign push_job.dead    = dead;
    assign push_job.ref_old = ref_old;
    assign push_job.col     = f1_col_reg;
    assign push_job.row     = f1_row_reg;
    assign push_job.last    = f1_last_reg;
    assign push_job.clear   = f1_clear_reg;
endmodule
`default_nettype wire

// File: hw/rtl/dcpc_back.sv
// Back part: class code, saturating tallies and output register.
`default_nettype none
module dcpc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire dcpc_pkg::job_t  q_job,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [127:0]         out_data,
    output logic                 out_last
);
    localparam int TW = dcpc_pkg::TALLY_W;

    logic [TW-1:0] found_reg, refc_reg, added_reg, missing_reg;
    logic [TW-1:0] found_next, refc_next, added_next, missing_next;
    logic [TW-1:0] found_b, refc_b, added_b, missing_b;
    logic          valid_reg;
    logic [127:0]  data_reg;
    logic          last_reg;
    dcpc_pkg::class_t code;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] t);
        return (t < dcpc_pkg::TALLY_MAX) ? t + TW'(1) : dcpc_pkg::TALLY_MAX;
    endfunction

    assign pop = q_valid && (!valid_reg || out_ready);

    always_comb begin
        case ({q_job.dead, q_job.ref_old})
            2'b11:   code = dcpc_pkg::CLASS_BOTH;
            2'b10:   code = dcpc_pkg::CLASS_ADDED;
            2'b01:   code = dcpc_pkg::CLASS_MISSING;
            default: code = dcpc_pkg::CLASS_CLEAN;
        endcase
        found_b   = q_job.clear ? '0 : found_reg;
        refc_b    = q_job.clear ? '0 : refc_reg;
        added_b   = q_job.clear ? '0 : added_reg;
        missing_b = q_job.clear ? '0 : missing_reg;
        found_next   = q_job.dead ? sat_inc(found_b) : found_b;
        refc_next    = q_job.ref_old ? sat_inc(refc_b) : refc_b;
        added_next   = (code == dcpc_pkg::CLASS_ADDED) ? sat_inc(added_b) : added_b;
        missing_next = (code == dcpc_pkg::CLASS_MISSING) ? sat_inc(missing_b) : missing_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= '0;
            refc_reg    <= '0;
            added_reg   <= '0;
            missing_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                found_reg   <= found_next;
                refc_reg    <= refc_next;
                added_reg   <= added_next;
                missing_reg <= missing_next;
                valid_reg   <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= {2'b00, missing_next, added_next, refc_next, found_next,
                         q_job.row, q_job.col, code};
            last_reg <= q_job.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;
endmodule
`default_nettype wire

// File: hw/rtl/dead_column_pixel_classifier_core.sv
// Top level of the dead column pixel classifier.
//
// Pixels arrive in raster order on the s_ channel, one word per pixel, with
// start_of_frame in s_tuser. Each interior pixel (column 2..W-3, row 2..H-3)
// yields one result word on the m_ channel: class code, position and the four
// saturating running counts; m_tlast marks the last interior pixel of a frame.
// The result for pixel (c, r) leaves after pixel (c, r+2) has been taken.
// The block takes one pixel per cycle while s_tready is high. A result passes
// through the line memory read, the job queue and the output register on its
// way to m_. When the receiver stalls, the four-entry job queue fills and
// s_tready drops; no word is lost. Registers are written on the cfg_ channel,
// which is always ready; the user must write them only while the stream is
// idle, which the block does not enforce. Reset clears position, counts, queue
// and output; the flag line memories are not cleared and hold valid data once
// the first rows of a frame begun at the origin have been taken.
`default_nettype none
module dead_column_pixel_classifier_core #(
    parameter int MAX_WIDTH   = dcpc_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = dcpc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pixel_value[15:0], ref_value[31:16]
    input  wire logic [31:0]  s_tdata,
    // start_of_frame[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // class_code[1:0], pixel_col[13:2], pixel_row[25:14], count_found[50:26],
    // count_reference[75:51], count_added[100:76], count_missing[125:101]
    output logic [127:0]      m_tdata,
    output logic              m_tlast
);
    localparam int QD = dcpc_pkg::QUEUE_DEPTH;

    dcpc_pkg::cfg_t cfg_reg;
    dcpc_pkg::job_t push_job, q_job;
    logic push, pop, q_valid;
    logic [$clog2(QD+1)-1:0] q_level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= 13'd4096;
            cfg_reg.frame_height  <= 13'd4096;
            cfg_reg.mean_level    <= 16'd0;
            cfg_reg.noise_sigma   <= 14'd0;
            cfg_reg.ref_threshold <= 16'd32768;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dcpc_pkg::REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data[12:0];
                dcpc_pkg::REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data[12:0];
                dcpc_pkg::REG_MEAN_LEVEL:    cfg_reg.mean_level    <= cfg_data;
                dcpc_pkg::REG_NOISE_SIGMA:   cfg_reg.noise_sigma   <= cfg_data[13:0];
                dcpc_pkg::REG_REF_THRESHOLD: cfg_reg.ref_threshold <= cfg_data;
                default: ;
            endcase
        end
    end

    dcpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS),
        .QDEPTH     (QD)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .pix_valid     (s_tvalid),
        .pix_ready     (s_tready),
        .pixel_value   (s_tdata[15:0]),
        .ref_value     (s_tdata[31:16]),
        .start_of_frame(s_tuser[0]),
        .q_level       (q_level),
        .push          (push),
        .push_job      (push_job)
    );

    dcpc_queue #(
        .DEPTH(QD)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_level (q_level)
    );

    dcpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );
endmodule
`default_nettype wire
